// File: hdl/asgr_pkg.sv
package asgr_pkg;

    localparam int CODE_BITS = 16;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    typedef logic [CODE_BITS-1:0] code_t;

    // dflt set means the note default colour; idx is then zero
    typedef struct packed {
        logic       dflt;
        logic [7:0] idx;
    } colour_t;

    localparam colour_t COLOUR_DEFAULT = '{dflt: 1'b1, idx: 8'd0};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } char_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_text;
        logic       fore_default;
        logic [7:0] fore_index;
        logic       back_default;
        logic [7:0] back_index;
        logic [3:0] style_bits;
        logic       last;
    } attr_t;

endpackage

// File: hdl/asgr_char_if.sv
interface asgr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: hdl/asgr_attr_if.sv
interface asgr_attr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_text;
    logic       fore_default;
    logic [7:0] fore_index;
    logic       back_default;
    logic [7:0] back_index;
    logic [3:0] style_bits;
    logic       last;

    modport source (
        output valid, output out_byte, output is_text, output fore_default,
        output fore_index, output back_default, output back_index,
        output style_bits, output last, input ready
    );
    modport sink (
        input valid, input out_byte, input is_text, input fore_default,
        input fore_index, input back_default, input back_index,
        input style_bits, input last, output ready
    );
endinterface

// File: hdl/asgr_parser.sv
module asgr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  asgr_pkg::char_t  char_in,
    output asgr_pkg::attr_t  result,
    output logic             emit
);

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_ESC       = 3'd1,
        ST_CODE      = 3'd2,
        ST_FG_START  = 3'd3,
        ST_FG_FINISH = 3'd4,
        ST_BG_START  = 3'd5,
        ST_BG_FINISH = 3'd6
    } parse_state_t;

    parse_state_t      state_reg, state_next, state_proc;
    asgr_pkg::code_t   accum_reg, accum_next, accum_proc, accum_x10;
    logic [3:0]        style_reg, style_next, style_proc;
    asgr_pkg::colour_t fore_reg, fore_next, fore_proc;
    asgr_pkg::colour_t back_reg, back_next, back_proc;
    asgr_pkg::colour_t fnorm_reg, fnorm_next, fnorm_proc;
    asgr_pkg::colour_t fbold_reg, fbold_next, fbold_proc;
    logic [7:0]        b;
    logic              fin;
    logic              text;
    logic              is_digit;

    assign b         = char_in.text_byte;
    assign fin       = char_in.end_of_text;
    assign is_digit  = (b >= asgr_pkg::CH_ZERO) && (b <= asgr_pkg::CH_NINE);
    assign accum_x10 = (accum_reg << 3) + (accum_reg << 1);

    always_comb
    begin
        state_proc = state_reg;
        accum_proc = accum_reg;
        style_proc = style_reg;
        fore_proc  = fore_reg;
        back_proc  = back_reg;
        fnorm_proc = fnorm_reg;
        fbold_proc = fbold_reg;
        text       = 1'b0;

        if (b == asgr_pkg::CH_ESC)
        begin
            state_proc = ST_ESC;
        end
        else if (state_reg == ST_NONE)
        begin
            text = 1'b1;
        end
        else if (b == asgr_pkg::CH_LBRACKET)
        begin
            if (state_reg == ST_ESC)
            begin
                state_proc = ST_CODE;
                accum_proc = '0;
            end
            else
            begin
                state_proc = ST_NONE;
            end
        end
        else if (is_digit)
        begin
            if (state_reg != ST_ESC)
                accum_proc = accum_x10 + asgr_pkg::code_t'(b[3:0]);
        end
        else if ((b == asgr_pkg::CH_SEMI) || (b == asgr_pkg::CH_M))
        begin
            case (state_reg)
                ST_CODE:
                begin
                    if (accum_reg == asgr_pkg::code_t'(0))
                    begin
                        style_proc = 4'd0;
                        fnorm_proc = '{dflt: 1'b0, idx: 8'd7};
                        fbold_proc = '{dflt: 1'b0, idx: 8'd15};
                        back_proc  = '{dflt: 1'b0, idx: 8'd0};
                        fore_proc  = '{dflt: 1'b0, idx: 8'd7};
                    end
                    else if (accum_reg == asgr_pkg::code_t'(1))
                    begin
                        fore_proc     = fbold_reg;
                        style_proc[0] = 1'b1;
                    end
                    else if (accum_reg == asgr_pkg::code_t'(7))
                        style_proc[3] = 1'b1;
                    else if ((accum_reg == asgr_pkg::code_t'(3))
                             || (accum_reg == asgr_pkg::code_t'(5))
                             || (accum_reg == asgr_pkg::code_t'(6)))
                        style_proc[2] = 1'b1;
                    else if (accum_reg == asgr_pkg::code_t'(4))
                        style_proc[1] = 1'b1;
                    else if (accum_reg == asgr_pkg::code_t'(22))
                    begin
                        fore_proc     = fnorm_reg;
                        style_proc[0] = 1'b0;
                    end
                    else if (accum_reg == asgr_pkg::code_t'(27))
                        style_proc[3] = 1'b0;
                    else if ((accum_reg == asgr_pkg::code_t'(23))
                             || (accum_reg == asgr_pkg::code_t'(25)))
                        style_proc[2] = 1'b0;
                    else if (accum_reg == asgr_pkg::code_t'(24))
                        style_proc[1] = 1'b0;
                    else if ((accum_reg >= asgr_pkg::code_t'(30))
                             && (accum_reg <= asgr_pkg::code_t'(37)))
                    begin
                        fnorm_proc = '{dflt: 1'b0, idx: {5'd0, accum_reg[2:0] - 3'd6}};
                        fbold_proc = '{dflt: 1'b0, idx: {5'd1, accum_reg[2:0] - 3'd6}};
                        fore_proc  = style_reg[0] ? fbold_proc : fnorm_proc;
                    end
                    else if ((accum_reg >= asgr_pkg::code_t'(40))
                             && (accum_reg <= asgr_pkg::code_t'(47)))
                        back_proc = '{dflt: 1'b0, idx: {5'd0, accum_reg[2:0]}};
                    else if (accum_reg == asgr_pkg::code_t'(38))
                        state_proc = ST_FG_START;
                    else if (accum_reg == asgr_pkg::code_t'(48))
                        state_proc = ST_BG_START;
                end
                ST_FG_START:
                    state_proc = (accum_reg == asgr_pkg::code_t'(5)) ? ST_FG_FINISH : ST_CODE;
                ST_FG_FINISH:
                begin
                    fnorm_proc = '{dflt: 1'b0, idx: accum_reg[7:0]};
                    fbold_proc = fnorm_proc;
                    fore_proc  = fnorm_proc;
                    state_proc = ST_CODE;
                end
                ST_BG_START:
                    state_proc = (accum_reg == asgr_pkg::code_t'(5)) ? ST_BG_FINISH : ST_CODE;
                ST_BG_FINISH:
                begin
                    back_proc  = '{dflt: 1'b0, idx: accum_reg[7:0]};
                    state_proc = ST_CODE;
                end
                default:
                begin
                end
            endcase
            accum_proc = '0;
            if (b == asgr_pkg::CH_M)
                state_proc = ST_NONE;
        end
    end

    // end of note returns everything to its power-up values
    always_comb
    begin
        if (fin)
        begin
            state_next = ST_NONE;
            accum_next = '0;
            style_next = 4'd0;
            fore_next  = asgr_pkg::COLOUR_DEFAULT;
            back_next  = asgr_pkg::COLOUR_DEFAULT;
            fnorm_next = asgr_pkg::COLOUR_DEFAULT;
            fbold_next = asgr_pkg::COLOUR_DEFAULT;
        end
        else
        begin
            state_next = state_proc;
            accum_next = accum_proc;
            style_next = style_proc;
            fore_next  = fore_proc;
            back_next  = back_proc;
            fnorm_next = fnorm_proc;
            fbold_next = fbold_proc;
        end
    end

    assign emit                = text || fin;
    assign result.out_byte     = text ? b : 8'd0;
    assign result.is_text      = text;
    assign result.fore_default = fore_proc.dflt;
    assign result.fore_index   = fore_proc.dflt ? 8'd0 : fore_proc.idx;
    assign result.back_default = back_proc.dflt;
    assign result.back_index   = back_proc.dflt ? 8'd0 : back_proc.idx;
    assign result.style_bits   = style_proc;
    assign result.last         = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NONE;
            accum_reg <= '0;
            style_reg <= 4'd0;
            fore_reg  <= asgr_pkg::COLOUR_DEFAULT;
            back_reg  <= asgr_pkg::COLOUR_DEFAULT;
            fnorm_reg <= asgr_pkg::COLOUR_DEFAULT;
            fbold_reg <= asgr_pkg::COLOUR_DEFAULT;
        end
        else if (step)
        begin
            state_reg <= state_next;
            accum_reg <= accum_next;
            style_reg <= style_next;
            fore_reg  <= fore_next;
            back_reg  <= back_next;
            fnorm_reg <= fnorm_next;
            fbold_reg <= fbold_next;
        end
    end

endmodule

// File: hdl/ansi_sgr_stream_parser_core.sv
// channel    dir  handshake     payload
// char_in    in   valid/ready   text_byte[7:0], end_of_text
// char_out   out  valid/ready   out_byte, is_text, fore/back default+index, style_bits, last
//
// One byte per clock sustained while char_out is not stalled; a byte's result reaches char_out
// through the input register, the parser step and the result register, in that order; only
// text bytes and the end of note produce a result.
// rst_n (async, active low) puts the parser outside any sequence with default colours.
// A stalled result holds; char_in keeps accepting until both registers are full.
module ansi_sgr_stream_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    asgr_char_if.sink   char_in,
    asgr_attr_if.source char_out
);

    asgr_pkg::char_t in_data_reg;
    logic            in_valid_reg;
    asgr_pkg::attr_t out_data_reg;
    logic            out_valid_reg;
    asgr_pkg::attr_t result;
    logic            emit;
    logic            step;

    // the held byte moves on whenever the result slot is free or being emptied
    assign step          = in_valid_reg && (!out_valid_reg || char_out.ready);
    assign char_in.ready = !in_valid_reg || step;

    asgr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (in_data_reg),
        .result  (result),
        .emit    (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_in.ready)
                in_valid_reg <= char_in.valid;
            if (step)
                out_valid_reg <= emit;
            else if (char_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            in_data_reg.text_byte   <= char_in.text_byte;
            in_data_reg.end_of_text <= char_in.end_of_text;
        end
        if (step && emit)
            out_data_reg <= result;
    end

    assign char_out.valid        = out_valid_reg;
    assign char_out.out_byte     = out_data_reg.out_byte;
    assign char_out.is_text      = out_data_reg.is_text;
    assign char_out.fore_default = out_data_reg.fore_default;
    assign char_out.fore_index   = out_data_reg.fore_index;
    assign char_out.back_default = out_data_reg.back_default;
    assign char_out.back_index   = out_data_reg.back_index;
    assign char_out.style_bits   = out_data_reg.style_bits;
    assign char_out.last         = out_data_reg.last;

endmodule

// File: hdl/asgr_checker.sv
module asgr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_text,
    input logic       fore_default,
    input logic [7:0] fore_index,
    input logic       back_default,
    input logic [7:0] back_index,
    input logic       last
);

    // a non-text transaction only ever closes the note
    a_swallowed_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_text |-> last && (out_byte == 8'd0))
        else $error("non-text result that is not the final one");

    a_default_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!fore_default || (fore_index == 8'd0))
                   && (!back_default || (back_index == 8'd0)))
        else $error("default colour with non-zero index");

    // input only backs up behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while result side free");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

endmodule

bind ansi_sgr_stream_parser_core asgr_checker u_asgr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (char_in.ready),
    .out_valid    (char_out.valid),
    .out_ready    (char_out.ready),
    .out_byte     (char_out.out_byte),
    .is_text      (char_out.is_text),
    .fore_default (char_out.fore_default),
    .fore_index   (char_out.fore_index),
    .back_default (char_out.back_default),
    .back_index   (char_out.back_index),
    .last         (char_out.last)
);
